### hdl/aos_pkg.sv
// package for the adaptive operator selector
// holds sizes, command codes and the status struct between sequencer and divider
package aos_pkg;
  localparam int unsigned RemovalOps   = 4;
  localparam int unsigned InsertionOps = 3;
  localparam int unsigned NoiseOps     = 2;
  localparam int unsigned TotalOps     = RemovalOps + NoiseOps + InsertionOps;
  localparam int unsigned NoiseBase    = RemovalOps;
  localparam int unsigned InsBase      = RemovalOps + NoiseOps;
  localparam int unsigned SlotW        = $clog2(TotalOps);
  localparam int unsigned WeightW      = 24;
  localparam int unsigned SumW         = 32;
  localparam int unsigned CountW       = 16;
  localparam int unsigned FracW        = 16;
  localparam logic [15:0] RfReset      = 16'd6554;
  localparam logic [WeightW-1:0] WOne  = 24'd65536;

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_REWARD = 2'd1,
    CMD_SEGEND = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### hdl/aos_if.sv
// valid/ready channel interfaces for the selector
interface aos_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] rand_removal;
  logic [15:0] rand_noise;
  logic [15:0] rand_insertion;
  logic [2:0]  removal_op;
  logic        noise_op;
  logic [2:0]  insertion_op;
  logic [15:0] reward;
  modport source (output valid, cmd, rand_removal, rand_noise, rand_insertion,
                  removal_op, noise_op, insertion_op, reward, input ready);
  modport sink (input valid, cmd, rand_removal, rand_noise, rand_insertion,
                removal_op, noise_op, insertion_op, reward, output ready);
endinterface

interface aos_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] removal_choice;
  logic       noise_choice;
  logic [2:0] insertion_choice;
  logic       choice_valid;
  modport source (output valid, removal_choice, noise_choice, insertion_choice,
                  choice_valid, input ready);
  modport sink (input valid, removal_choice, noise_choice, insertion_choice,
                choice_valid, output ready);
endinterface

### hdl/aos_div.sv
// shared restoring divider: 40-bit dividend by 16-bit divisor, one bit a cycle
// depends on aos_pkg
module aos_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [39:0]            dividend_i,
  input  logic [15:0]            divisor_i,
  output aos_pkg::div_ctl_t      ctl_o,
  output logic [39:0]            quot_o
);
  import aos_pkg::*;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [39:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d, trial;
  logic [15:0] dvs_q, dvs_d;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[15:0], quo_q[39]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quo_q;
endmodule

### hdl/adaptive_operator_selector.sv
// adaptive operator selector top level: weights, scores, sequencer
// depends on aos_pkg, aos_if, aos_div
//
// usage: one input channel (cmd plus three random fractions, reward fields)
// and one output channel, valid/ready each; a transfer happens when both high.
// every input item yields exactly one result item; picks are zero and
// choice_valid low unless the item is a select.
// the reaction factor is written through cfg_we_i / cfg_data_i; the user must
// do so only while idle, as the block itself does not enforce it.
// a select sums and then walks each group's weights, one weight a cycle;
// a reward updates its three slots in turn; segment end runs each used
// operator through the shared divider and then one multiply-add pair,
// and skips each unused operator.
// one item at a time: in_ready is high only when the sequencer is idle and
// the result register is empty. a stalled receiver holds the result and
// blocks the next item. reset returns weights to 1.0, clears sums and counts
// and loads the default reaction factor.
module adaptive_operator_selector (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_data_i,
  aos_in_if.sink    in_i,
  aos_out_if.source out_o
);
  import aos_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_REW   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MIX   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] rf_q;
  logic [WeightW-1:0] w_q [TotalOps];
  logic [SumW-1:0]    s_q [TotalOps];
  logic [CountW-1:0]  c_q [TotalOps];
  logic [1:0]  cmd_q;
  logic [15:0] rr_q, rn_q, ri_q, rew_q;
  logic [2:0]  rop_q, iop_q;
  logic        nop_q;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [1:0]  grp_q, grp_d;       // 0 removal, 1 noise, 2 insertion
  logic [27:0] sum_q, sum_d, cum_q, cum_d;
  logic [2:0]  pick_q, pick_d, base_pick;
  logic        stop_q, stop_d;
  logic [2:0]  pr_q, pi_q; logic pn_q;
  logic [2:0]  pr_d, pi_d; logic pn_d;
  logic        ov_q, ov_d;
  logic [2:0]  orc_q, oic_q; logic onc_q, ocv_q;
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [39:0] quot;
  logic [WeightW-1:0] mean_q;
  logic [40:0] mix_q;
  logic        mix_ph_q;
  logic [SlotW-1:0] gstart, gend;
  logic [2:0]  gsize;
  logic [15:0] rsel;
  logic [43:0] lhs, rhs;

  aos_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({s_q[idx_q], 8'd0}), .divisor_i(c_q[idx_q]),
    .ctl_o(div_ctl), .quot_o(quot)
  );

  always_comb begin
    unique case (grp_q)
      2'd0:    begin gstart = '0; gsize = 3'(RemovalOps - 1);
                     rsel = rr_q; end
      2'd1:    begin gstart = SlotW'(NoiseBase); gsize = 3'(NoiseOps - 1);
                     rsel = rn_q; end
      default: begin gstart = SlotW'(InsBase); gsize = 3'(InsertionOps - 1);
                     rsel = ri_q; end
    endcase
    gend = gstart + SlotW'(gsize);
    base_pick = 3'(idx_q - gstart);
    lhs = 44'(rsel) * 44'(sum_q);
    rhs = {cum_q + 28'(w_q[idx_q]), 16'd0};
  end

  assign in_i.ready = (state_q == ST_IDLE) && !ov_q;
  assign out_o.valid = ov_q;
  assign out_o.removal_choice = orc_q;
  assign out_o.noise_choice = onc_q;
  assign out_o.insertion_choice = oic_q;
  assign out_o.choice_valid = ocv_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; grp_d = grp_q;
    sum_d = sum_q; cum_d = cum_q; pick_d = pick_q; stop_d = stop_q;
    pr_d = pr_q; pn_d = pn_q; pi_d = pi_q; ov_d = ov_q;
    div_start = 1'b0;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_i.valid && in_i.ready) begin
        pr_d = '0; pn_d = 1'b0; pi_d = '0;
        unique case (cmd_e'(in_i.cmd))
          CMD_SELECT: begin
            state_d = ST_SUM; grp_d = 2'd0; idx_d = '0; sum_d = '0;
          end
          CMD_REWARD: begin state_d = ST_REW; idx_d = '0; end
          CMD_SEGEND: begin state_d = ST_DIV; idx_d = '0; end
          default:    state_d = ST_OUT;
        endcase
      end
      ST_SUM: begin
        sum_d = sum_q + 28'(w_q[idx_q]);
        if (idx_q == gend) begin
          state_d = ST_WALK; idx_d = gstart; cum_d = '0;
          pick_d = '0; stop_d = 1'b0;
        end else idx_d = idx_q + 1'b1;
      end
      ST_WALK: begin
        cum_d = rhs[43:16];
        if (!stop_q && lhs > rhs) pick_d = base_pick + 3'd1;
        else stop_d = 1'b1;
        if (idx_q == gend) begin
          logic [2:0] fp;
          fp = (!stop_q && lhs > rhs) ? base_pick + 3'd1 : pick_d;
          if (fp > gsize) fp = gsize;
          unique case (grp_q)
            2'd0:    pr_d = fp;
            2'd1:    pn_d = fp[0];
            default: pi_d = fp;
          endcase
          if (grp_q == 2'd2) state_d = ST_OUT;
          else begin
            grp_d = grp_q + 2'd1; state_d = ST_SUM; sum_d = '0;
            idx_d = gend + 1'b1;
          end
        end else idx_d = idx_q + 1'b1;
      end
      ST_REW: begin
        if (idx_q == SlotW'(2)) state_d = ST_OUT;
        idx_d = idx_q + 1'b1;
      end
      ST_DIV: begin
        if (!div_ctl.busy && !div_ctl.done && !mix_ph_q) begin
          if (c_q[idx_q] == '0) begin
            if (idx_q == SlotW'(TotalOps - 1)) state_d = ST_OUT;
            idx_d = idx_q + 1'b1;
          end else div_start = 1'b1;
        end else if (div_ctl.done) state_d = ST_MIX;
      end
      ST_MIX: if (mix_ph_q) begin
        if (idx_q == SlotW'(TotalOps - 1)) state_d = ST_OUT;
        else state_d = ST_DIV;
        idx_d = idx_q + 1'b1;
      end
      ST_OUT: if (!ov_q) begin
        ov_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ov_q <= 1'b0; rf_q <= RfReset;
      idx_q <= '0; grp_q <= '0; mix_ph_q <= 1'b0;
      for (int k = 0; k < TotalOps; k++) begin
        w_q[k] <= WOne; s_q[k] <= '0; c_q[k] <= '0;
      end
    end else begin
      state_q <= state_d; ov_q <= ov_d; idx_q <= idx_d; grp_q <= grp_d;
      if (cfg_we_i) rf_q <= cfg_data_i;
      if (state_q == ST_REW) begin
        logic ok;
        logic [SlotW-1:0] sl;
        logic [32:0] ns;
        ok = 1'b1; sl = '0;
        unique case (idx_q[1:0])
          2'd0:    begin ok = 32'(rop_q) < RemovalOps; sl = SlotW'(rop_q); end
          2'd1:    sl = SlotW'(NoiseBase) + SlotW'(nop_q);
          default: begin ok = 32'(iop_q) < InsertionOps;
                         sl = SlotW'(InsBase) + SlotW'(iop_q); end
        endcase
        ns = {1'b0, s_q[sl]} + 33'(rew_q);
        if (ok) begin
          s_q[sl] <= ns[32] ? '1 : ns[31:0];
          if (c_q[sl] != '1) c_q[sl] <= c_q[sl] + 1'b1;
        end
      end
      mix_ph_q <= 1'b0;
      if (state_q == ST_MIX) begin
        // first phase: old weight term, second phase: add mean term and write back
        if (!mix_ph_q) begin
          mix_q <= 41'(w_q[idx_q]) * 41'(17'h10000 - 17'(rf_q));
          mix_ph_q <= 1'b1;
        end else begin
          logic [40:0] t;
          t = mix_q + 41'(rf_q) * 41'(mean_q);
          w_q[idx_q] <= (t[40:16] > 25'hFFFFFF) ? '1 : t[39:16];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.cmd; rr_q <= in_i.rand_removal; rn_q <= in_i.rand_noise;
      ri_q <= in_i.rand_insertion; rop_q <= in_i.removal_op;
      nop_q <= in_i.noise_op; iop_q <= in_i.insertion_op; rew_q <= in_i.reward;
    end
    sum_q <= sum_d; cum_q <= cum_d; pick_q <= pick_d; stop_q <= stop_d;
    pr_q <= pr_d; pn_q <= pn_d; pi_q <= pi_d;
    if (div_ctl.done) mean_q <= (quot > 40'hFFFFFF) ? '1 : quot[23:0];
    if (state_q == ST_OUT && !ov_q) begin
      orc_q <= pr_q; onc_q <= pn_q; oic_q <= pi_q;
      ocv_q <= (cmd_e'(cmd_q) == CMD_SELECT);
    end
  end
endmodule
